>>> hdl/utx_pkg.sv
// utx_pkg: shared types and constants for the uart transmitter with fifo
// no dependencies; imported by the interfaces and every module of the block but utx_ram

package utx_pkg;

  // frame format and field widths
  localparam int unsigned DATA_BITS  = 8;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned BIT_CNT_W  = 4;

  // command codes carried on the input channel
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_TICK  = 1'b1
  } utx_op_e;

  // frame phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_STOP  = 4'b1000
  } utx_phase_e;

  // one classified command
  typedef struct packed {
    utx_op_e                op;
    logic [DATA_BITS-1:0]   data;
  } utx_cmd_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic      valid;
    utx_cmd_t  cmd;
  } utx_cmdq_t;

endpackage

>>> hdl/utx_if.sv
// utx_if: valid/ready channel interfaces for commands in and status out
// depends on utx_pkg for field widths

interface utx_cmd_if
  import utx_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic                  opcode;
  logic [DATA_BITS-1:0]  data_byte;

  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink   (input valid, input opcode, input data_byte, output ready);
endinterface

interface utx_rsp_if
  import utx_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                line_level;
  logic                write_accepted;
  logic [COUNT_W-1:0]  fifo_count;
  logic                sending;

  modport source (output valid, output line_level, output write_accepted,
                  output fifo_count, output sending, input ready);
  modport sink   (input valid, input line_level, input write_accepted,
                  input fifo_count, input sending, output ready);
endinterface

>>> hdl/utx_ram.sv
// utx_ram: generic single-write, single-read ram with registered read data
// no dependencies

module utx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [$clog2(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/utx_front.sv
// utx_front: accepts command beats, decodes the opcode and holds them in a
// two-entry queue for the back end; depends on utx_pkg and utx_cmd_if

module utx_front
  import utx_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  utx_cmd_if.sink        cmd,
  output utx_cmdq_t      head,
  input  logic           pop
);

  utx_cmd_t    slot [2];
  logic        wr_idx;
  logic        rd_idx;
  logic [1:0]  count;
  logic        push;
  utx_cmd_t    decoded;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;

  // classify the incoming beat
  always_comb begin
    decoded.op   = utx_op_e'(cmd.opcode);
    decoded.data = (decoded.op == OP_WRITE) ? cmd.data_byte : '0;
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_idx] <= decoded;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd   = slot[rd_idx];

endmodule

>>> hdl/utx_back.sv
// utx_back: byte fifo, 8n1 frame sequencer and result register
// depends on utx_pkg, utx_rsp_if and utx_ram

module utx_back
  import utx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  utx_cmdq_t  head,
  output logic       pop,
  utx_rsp_if.source  rsp
);

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);

  logic [PTR_W-1:0]      wp, wp_next;
  logic [PTR_W-1:0]      rp, rp_next;
  logic [DATA_BITS-1:0]  shift_byte, shift_byte_next, shift_eff;
  logic [BIT_CNT_W-1:0]  bit_count, bit_count_next;
  utx_phase_e            phase, phase_next;
  logic                  line_reg, line_reg_next;
  logic                  pend, pend_next;
  logic                  accepted;
  logic                  go;
  logic                  ram_we;
  logic [DATA_BITS-1:0]  ram_rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] level(input logic [PTR_W-1:0] w,
                                             input logic [PTR_W-1:0] r);
    return (w >= r) ? (w - r) : (PTR_W'(FIFO_DEPTH) - (r - w));
  endfunction

  // byte store, read at the read pointer every cycle
  utx_ram #(
    .WIDTH (DATA_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (head.cmd.data),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  // run one command when the result register is free
  assign go  = head.valid && (!rsp.valid || rsp.ready);
  assign pop = go;

  // a frame started from the store takes its byte from the registered ram read in the next cycle
  assign shift_eff = pend ? ram_rdata : shift_byte;

  // frame sequencer and fifo update
  always_comb begin
    wp_next         = wp;
    rp_next         = rp;
    shift_byte_next = shift_eff;
    bit_count_next  = bit_count;
    phase_next      = phase;
    line_reg_next   = line_reg;
    pend_next       = 1'b0;
    accepted        = 1'b0;
    ram_we          = 1'b0;
    if (go) begin
      if (head.cmd.op == OP_WRITE) begin
        if (ptr_inc(wp) != rp) begin
          ram_we   = 1'b1;
          wp_next  = ptr_inc(wp);
          accepted = 1'b1;
          // idle means the fifo was empty, so this byte goes out at once
          if (phase == PH_IDLE) begin
            shift_byte_next = head.cmd.data;
            rp_next         = ptr_inc(rp);
            bit_count_next  = '0;
            line_reg_next   = 1'b0;
            phase_next      = PH_START;
          end
        end
      end else begin
        unique case (phase)
          PH_IDLE: begin
          end
          PH_START: begin
            line_reg_next   = shift_eff[0];
            shift_byte_next = shift_eff >> 1;
            bit_count_next  = BIT_CNT_W'(1);
            phase_next      = PH_DATA;
          end
          PH_DATA: begin
            if (bit_count >= BIT_CNT_W'(DATA_BITS)) begin
              phase_next    = PH_STOP;
              line_reg_next = 1'b1;
            end else begin
              line_reg_next   = shift_eff[0];
              shift_byte_next = shift_eff >> 1;
              bit_count_next  = bit_count + BIT_CNT_W'(1);
            end
          end
          PH_STOP: begin
            if (wp != rp) begin
              pend_next      = 1'b1;
              rp_next        = ptr_inc(rp);
              bit_count_next = '0;
              line_reg_next  = 1'b0;
              phase_next     = PH_START;
            end else begin
              phase_next = PH_IDLE;
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
    end
  end

  // transmitter state
  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      rp         <= '0;
      shift_byte <= '0;
      bit_count  <= '0;
      phase      <= PH_IDLE;
      line_reg   <= 1'b1;
      pend       <= 1'b0;
    end else begin
      wp         <= wp_next;
      rp         <= rp_next;
      shift_byte <= shift_byte_next;
      bit_count  <= bit_count_next;
      phase      <= phase_next;
      line_reg   <= line_reg_next;
      pend       <= pend_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (go) begin
      rsp.line_level     <= line_reg_next;
      rsp.write_accepted <= accepted;
      rsp.fifo_count     <= COUNT_W'(level(wp_next, rp_next));
      rsp.sending        <= (phase_next != PH_IDLE);
    end
  end

endmodule

>>> hdl/uart_tx_with_fifo_top.sv
// uart_tx_with_fifo_top: 8n1 serial transmitter fed from a byte fifo
// depends on utx_pkg, utx_if, utx_front, utx_back and utx_ram
//
// usage:
//   cmd channel: one beat per command; opcode write stores data_byte in the
//     fifo (and starts a frame at once when the line is idle), opcode tick
//     advances the line by one bit period (start, 8 data bits lsb first, stop)
//   rsp channel: exactly one beat per command, in order, giving the line level,
//     whether a write was stored, the fifo fill and whether a frame is running
//   a write to a full fifo (FIFO_DEPTH-1 bytes waiting) is dropped and
//     reported with write_accepted low
//   flow: an accepted command is held in the command queue and its result in
//     the result register; one command per cycle is sustained while rsp.ready
//     stays high, set by the combinational sequencer step and the one-write, one-read fifo ram
//   a frame restarted from the fifo reads its byte from the ram on the next
//     cycle, in time for the following tick
//   reset: line high, fifo empty, queue and result register empty; no
//     clearing pass, the block takes commands in the first cycle after reset
//   receiver stall: the result register holds; the two-entry command queue
//     keeps taking beats until it fills, then cmd.ready drops

module uart_tx_with_fifo_top
  import utx_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  utx_cmd_if.sink    cmd,
  utx_rsp_if.source  rsp
);

  utx_cmdq_t  head;
  logic       pop;

  // accept and decode side
  utx_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .head (head),
    .pop  (pop)
  );

  // fifo and line side
  utx_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .rsp  (rsp)
  );

endmodule

>>> hdl/utx_checker.sv
// utx_checker: port-level assertions for uart_tx_with_fifo_top
// depends on utx_pkg; bound to the top level at the end of this file

module utx_checker
  import utx_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  logic                line_level,
  input  logic                write_accepted,
  input  logic [COUNT_W-1:0]  fifo_count,
  input  logic                sending
);

  // a stalled result beat stays and holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(line_level)
      && $stable(write_accepted) && $stable(fifo_count) && $stable(sending))
    else $error("result beat changed while stalled");

  // no result beat straight out of reset
  a_rsp_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result beat right after reset");

  // an idle transmitter leaves the line high
  a_idle_line: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !sending |-> line_level)
    else $error("line low while idle");

  // the transmitter only idles with an empty fifo
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !sending |-> fifo_count == '0)
    else $error("idle with bytes waiting");

  // a stored byte always leaves a frame in progress
  a_write_sends: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && write_accepted |-> sending)
    else $error("write stored but no frame running");

endmodule

bind uart_tx_with_fifo_top utx_checker u_utx_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .line_level     (rsp.line_level),
  .write_accepted (rsp.write_accepted),
  .fifo_count     (rsp.fifo_count),
  .sending        (rsp.sending)
);
